@@ rtl/core/t4icon_pkg.sv @@
// ----------------------------------------------------------------------------
// t4icon_pkg
// Shared types, constants and the color expansion for the tiled 4bpp icon
// decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package t4icon_pkg;

   localparam int ADDR_W             = 10;
   localparam int COLOR_W            = 16;
   localparam int RGBA_W             = 32;
   localparam int INDEX_W            = 4;
   localparam int BYTE_W             = 8;
   localparam int PALETTE_DEPTH      = 16;
   localparam int QUEUE_DEPTH        = 2;
   localparam int ICON_WIDTH_DEFAULT = 32;
   localparam int TILE_WIDTH_DEFAULT = 8;

   localparam logic OP_PALETTE_WRITE = 1'b0;
   localparam logic OP_DECODE_BYTE   = 1'b1;

   typedef struct packed {
      logic               op;
      logic [INDEX_W-1:0] palette_index;
      logic [COLOR_W-1:0] palette_color;
      logic [BYTE_W-1:0]  icon_byte;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] pixel_address;
      logic [RGBA_W-1:0] left_rgba;
      logic [RGBA_W-1:0] right_rgba;
      logic              icon_done;
   } rsp_type;

   // One classified transaction waiting between the front and the back.
   typedef struct packed {
      logic               is_pixel;
      logic [INDEX_W-1:0] palette_index;
      logic [COLOR_W-1:0] palette_color;
      logic [INDEX_W-1:0] left_index;
      logic [INDEX_W-1:0] right_index;
      logic [ADDR_W-1:0]  pixel_address;
      logic               icon_done;
   } entry_type;

   // BGR555 to RGBA8888. Bit 15 alone still makes the pixel opaque.
   function automatic logic [RGBA_W-1:0] color_to_rgba(input logic [COLOR_W-1:0] c);
      logic [7:0] alpha;
      alpha = (c == '0) ? 8'h00 : 8'hFF;
      return {alpha, c[14:10], 3'b000, c[9:5], 3'b000, c[4:0], 3'b000};
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/tiled_4bpp_icon_to_rgba_top.sv @@
// A decode transaction passes through the queue, the palette lookup stage and the result register.
// Throughput: one transaction per cycle while the output is not stalled, with the 2-entry queue and the one-entry
// palette lookup stage; palette writes give no result and never wait on the output.
// Reset clears the byte counter, the queue, both pipeline stages and the
// palette valid bits, so every palette entry reads as zero until written.
// ----------------------------------------------------------------------------
// tiled_4bpp_icon_to_rgba_top
// Decodes a tiled 4bpp icon with a BGR555 palette into linear RGBA8888 pixels.
// ----------------------------------------------------------------------------
`default_nettype none

module tiled_4bpp_icon_to_rgba_top #(
   parameter int ICON_WIDTH = t4icon_pkg::ICON_WIDTH_DEFAULT,
   parameter int TILE_WIDTH = t4icon_pkg::TILE_WIDTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  t4icon_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output t4icon_pkg::rsp_type rsp_data
);
   import t4icon_pkg::*;

   logic      push;
   entry_type push_entry;
   logic      queue_full;
   logic      pop;
   logic      head_valid;
   entry_type head_entry;

   t4icon_front #(
      .ICON_WIDTH (ICON_WIDTH),
      .TILE_WIDTH (TILE_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   t4icon_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   t4icon_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

@@ rtl/core/t4icon_front.sv @@
// ----------------------------------------------------------------------------
// t4icon_front
// Accepts transactions, classifies them and tracks the tile walk that gives
// each icon byte its linear pixel address.
// ----------------------------------------------------------------------------
`default_nettype none

module t4icon_front #(
   parameter int ICON_WIDTH = t4icon_pkg::ICON_WIDTH_DEFAULT,
   parameter int TILE_WIDTH = t4icon_pkg::TILE_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  t4icon_pkg::req_type   req_data,
   input  logic                  queue_full,
   output logic                  push,
   output t4icon_pkg::entry_type push_entry
);
   import t4icon_pkg::*;

   localparam int BYTES_PER_TROW = TILE_WIDTH / 2;
   localparam int TPR_RAW        = ICON_WIDTH / TILE_WIDTH;
   localparam int TILES_PER_ROW  = (TPR_RAW > 0) ? TPR_RAW : 1;
   localparam int ICON_BYTES     = ICON_WIDTH * ICON_WIDTH / 2;
   localparam int PX_W  = (BYTES_PER_TROW > 1) ? $clog2(BYTES_PER_TROW) : 1;
   localparam int PY_W  = $clog2(TILE_WIDTH);
   localparam int TX_W  = (TILES_PER_ROW > 1) ? $clog2(TILES_PER_ROW) : 1;
   localparam int POS_W = $clog2(ICON_BYTES);

   localparam logic [PX_W-1:0]  PX_LAST  = PX_W'(BYTES_PER_TROW - 1);
   localparam logic [PY_W-1:0]  PY_LAST  = PY_W'(TILE_WIDTH - 1);
   localparam logic [TX_W-1:0]  TX_LAST  = TX_W'(TILES_PER_ROW - 1);
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(ICON_BYTES - 1);

   // Address steps, taken modulo the address range since only sums are formed.
   localparam logic [ADDR_W-1:0] COL_STEP  = ADDR_W'(2);
   localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(ICON_WIDTH % (2 ** ADDR_W));
   localparam logic [ADDR_W-1:0] TCOL_STEP = ADDR_W'(TILE_WIDTH % (2 ** ADDR_W));
   localparam logic [ADDR_W-1:0] TROW_STEP =
      ADDR_W'((TILE_WIDTH * ICON_WIDTH) % (2 ** ADDR_W));

   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [PX_W-1:0]   px_ff, px_in;
   logic [PY_W-1:0]   py_ff, py_in;
   logic [TX_W-1:0]   tx_ff, tx_in;
   logic [ADDR_W-1:0] col_ff, col_in;
   logic [ADDR_W-1:0] rowoff_ff, rowoff_in;
   logic [ADDR_W-1:0] tcol_ff, tcol_in;
   logic [ADDR_W-1:0] trow_ff, trow_in;

   logic              accept;
   logic              pixel_accept;
   logic              last_byte;
   logic [ADDR_W-1:0] address;

   assign req_stall    = queue_full;
   assign accept       = req_valid && !queue_full;
   assign pixel_accept = accept && (req_data.op == OP_DECODE_BYTE);
   assign last_byte    = (pos_ff == POS_LAST);
   assign address      = trow_ff + rowoff_ff + tcol_ff + col_ff;

   assign push = accept;

   always_comb begin
      push_entry.is_pixel      = (req_data.op == OP_DECODE_BYTE);
      push_entry.palette_index = req_data.palette_index;
      push_entry.palette_color = req_data.palette_color;
      push_entry.left_index    = req_data.icon_byte[INDEX_W-1:0];
      push_entry.right_index   = req_data.icon_byte[BYTE_W-1:INDEX_W];
      push_entry.pixel_address = address;
      push_entry.icon_done     = last_byte;
   end

   // Nested counters: byte within tile row, row within tile, tile column, tile row.
   always_comb begin
      pos_in    = pos_ff;
      px_in     = px_ff;
      py_in     = py_ff;
      tx_in     = tx_ff;
      col_in    = col_ff;
      rowoff_in = rowoff_ff;
      tcol_in   = tcol_ff;
      trow_in   = trow_ff;
      if (pixel_accept) begin
         if (last_byte) begin
            pos_in    = '0;
            px_in     = '0;
            py_in     = '0;
            tx_in     = '0;
            col_in    = '0;
            rowoff_in = '0;
            tcol_in   = '0;
            trow_in   = '0;
         end else begin
            pos_in = pos_ff + POS_W'(1);
            if (px_ff == PX_LAST) begin
               px_in  = '0;
               col_in = '0;
               if (py_ff == PY_LAST) begin
                  py_in     = '0;
                  rowoff_in = '0;
                  if (tx_ff == TX_LAST) begin
                     tx_in   = '0;
                     tcol_in = '0;
                     trow_in = trow_ff + TROW_STEP;
                  end else begin
                     tx_in   = tx_ff + TX_W'(1);
                     tcol_in = tcol_ff + TCOL_STEP;
                  end
               end else begin
                  py_in     = py_ff + PY_W'(1);
                  rowoff_in = rowoff_ff + ROW_STEP;
               end
            end else begin
               px_in  = px_ff + PX_W'(1);
               col_in = col_ff + COL_STEP;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         px_ff     <= '0;
         py_ff     <= '0;
         tx_ff     <= '0;
         col_ff    <= '0;
         rowoff_ff <= '0;
         tcol_ff   <= '0;
         trow_ff   <= '0;
      end else begin
         pos_ff    <= pos_in;
         px_ff     <= px_in;
         py_ff     <= py_in;
         tx_ff     <= tx_in;
         col_ff    <= col_in;
         rowoff_ff <= rowoff_in;
         tcol_ff   <= tcol_in;
         trow_ff   <= trow_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/t4icon_queue.sv @@
// ----------------------------------------------------------------------------
// t4icon_queue
// Short in-order queue of classified transactions between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module t4icon_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  t4icon_pkg::entry_type push_entry,
   output logic                  full,
   input  logic                  pop,
   output logic                  head_valid,
   output t4icon_pkg::entry_type head_entry
);
   import t4icon_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   entry_type        slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == CNT_FULL);
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/t4icon_back.sv @@
// ----------------------------------------------------------------------------
// t4icon_back
// Executes queued transactions: palette writes, palette lookups and color
// expansion into the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module t4icon_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  t4icon_pkg::entry_type head_entry,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output t4icon_pkg::rsp_type   rsp_data
);
   import t4icon_pkg::*;

   logic [COLOR_W-1:0]       pal_mem [PALETTE_DEPTH];
   logic [PALETTE_DEPTH-1:0] pal_valid_ff, pal_valid_in;

   logic               a_valid_ff, a_valid_in;
   logic [ADDR_W-1:0]  a_addr_ff;
   logic               a_done_ff;
   logic [COLOR_W-1:0] a_lcolor_ff, a_rcolor_ff;
   logic               a_lok_ff, a_rok_ff;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;

   logic               out_free;
   logic               a_load;
   logic               pal_we;
   logic               rd_en;
   logic [COLOR_W-1:0] left_color;
   logic [COLOR_W-1:0] right_color;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign a_load   = !a_valid_ff || out_free;
   // A palette write never waits: it produces no result.
   assign pop      = head_valid && (!head_entry.is_pixel || a_load);
   assign pal_we   = pop && !head_entry.is_pixel;
   assign rd_en    = pop && head_entry.is_pixel;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Entries never written read as zero through their valid bits.
   assign left_color  = a_lok_ff ? a_lcolor_ff : '0;
   assign right_color = a_rok_ff ? a_rcolor_ff : '0;

   always_comb begin
      pal_valid_in = pal_valid_ff;
      if (pal_we) begin
         pal_valid_in[head_entry.palette_index] = 1'b1;
      end
      a_valid_in   = a_load ? rd_en : a_valid_ff;
      rsp_valid_in = out_free ? a_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pal_valid_ff <= '0;
         a_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pal_valid_ff <= pal_valid_in;
         a_valid_ff   <= a_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pal_we) begin
         pal_mem[head_entry.palette_index] <= head_entry.palette_color;
      end
      if (rd_en) begin
         a_lcolor_ff <= pal_mem[head_entry.left_index];
         a_rcolor_ff <= pal_mem[head_entry.right_index];
         a_lok_ff    <= pal_valid_ff[head_entry.left_index];
         a_rok_ff    <= pal_valid_ff[head_entry.right_index];
         a_addr_ff   <= head_entry.pixel_address;
         a_done_ff   <= head_entry.icon_done;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         rsp_data_ff.pixel_address <= a_addr_ff;
         rsp_data_ff.left_rgba     <= color_to_rgba(left_color);
         rsp_data_ff.right_rgba    <= color_to_rgba(right_color);
         rsp_data_ff.icon_done     <= a_done_ff;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/t4icon_checker.sv @@
// ----------------------------------------------------------------------------
// t4icon_checker
// Port-level checks on the icon decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module t4icon_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input t4icon_pkg::req_type req_data,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input t4icon_pkg::rsp_type rsp_data
);
   import t4icon_pkg::*;

   logic req_seen;
   assign req_seen = req_valid && (req_data.op == OP_DECODE_BYTE || req_data.op == OP_PALETTE_WRITE);

   // A result that is stalled stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result transaction withdrawn while stalled");

   // A stalled result keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("result payload changed while stalled");

   // After reset nothing is pending and new transactions are taken.
   assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pending state survived reset");

   // The front only backs up when a result is stuck at the output.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no result pending");

   // While the input is stalled, a result that was stalled is not withdrawn.
   assert property (@(posedge clock) disable iff (reset)
      req_seen && req_stall |=> !(rsp_valid == 1'b0 && $past(rsp_stall) && $past(rsp_valid)
                                   && $past(req_stall)) || rsp_valid)
      else $error("stalled input with result lost");

endmodule

bind tiled_4bpp_icon_to_rgba_top t4icon_checker u_checker (.*);

`default_nettype wire

@@ verif/tb_tiled_4bpp_icon_to_rgba_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tiled_4bpp_icon_to_rgba_top
// Self-checking bench for the tiled 4bpp icon decoder. A behavioral palette
// and byte counter predict every pixel pair, and the results are checked in
// order. Directed palette and pixel transactions come first, followed by
// random traffic under several idle and stall mixes and one long receiver
// hold-off.
// ----------------------------------------------------------------------------

module tb_tiled_4bpp_icon_to_rgba_top;
   import t4icon_pkg::*;

   localparam int ICON_W         = ICON_WIDTH_DEFAULT;
   localparam int TILE_W         = TILE_WIDTH_DEFAULT;
   localparam int BYTES_PER_TROW = TILE_W / 2;
   localparam int BYTES_PER_TILE = BYTES_PER_TROW * TILE_W;
   localparam int TILES_PER_ROW  = (ICON_W / TILE_W == 0) ? 1 : ICON_W / TILE_W;
   localparam int ICON_BYTES     = ICON_W * ICON_W / 2;
   localparam int LONG_HOLD      = 300;
   localparam int STALL_LIMIT    = 3000;
   localparam int PHASE_ITEMS    = 450;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   req_type pending_requests[$];
   rsp_type expected_pixels[$];

   logic [COLOR_W-1:0] palette_model[PALETTE_DEPTH];
   int unsigned        byte_count_model = 0;

   int error_count    = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   bit long_hold_req  = 1'b0;
   bit long_hold_done = 1'b0;
   int hold_count     = 0;
   int quiet_cycles   = 0;

   tiled_4bpp_icon_to_rgba_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic logic [RGBA_W-1:0] bgr555_to_rgba(input logic [COLOR_W-1:0] c);
      logic [31:0] red, green, blue, alpha;
      red   = {27'd0, c[4:0]} << 3;
      green = {27'd0, c[9:5]} << 3;
      blue  = {27'd0, c[14:10]} << 3;
      alpha = (c == 16'h0000) ? 32'h0 : 32'hFF;
      return (alpha << 24) | (blue << 16) | (green << 8) | red;
   endfunction

   // Tile-order byte position to the linear index of its left pixel.
   function automatic logic [ADDR_W-1:0] linear_address(input int unsigned pos);
      int unsigned tile, tile_offset, row, col;
      tile        = pos / BYTES_PER_TILE;
      tile_offset = pos % BYTES_PER_TILE;
      row    = (tile / TILES_PER_ROW) * TILE_W + tile_offset / BYTES_PER_TROW;
      col    = (tile % TILES_PER_ROW) * TILE_W + (tile_offset % BYTES_PER_TROW) * 2;
      return ADDR_W'((row * ICON_W + col) & 32'h3FF);
   endfunction

   task automatic predict_request(input req_type item);
      rsp_type pixel_pair;
      if (item.op == OP_PALETTE_WRITE) begin
         palette_model[item.palette_index] = item.palette_color;
      end else begin
         pixel_pair.pixel_address = linear_address(byte_count_model);
         pixel_pair.left_rgba     = bgr555_to_rgba(palette_model[item.icon_byte[3:0]]);
         pixel_pair.right_rgba    = bgr555_to_rgba(palette_model[item.icon_byte[7:4]]);
         pixel_pair.icon_done     = (byte_count_model + 1 >= ICON_BYTES);
         byte_count_model = pixel_pair.icon_done ? 0 : byte_count_model + 1;
         expected_pixels.push_back(pixel_pair);
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
   endtask

   function automatic req_type make_request(input logic op, input logic [3:0] index,
                                            input logic [15:0] color, input logic [7:0] icon);
      req_type item;
      item.op            = op;
      item.palette_index = index;
      item.palette_color = color;
      item.icon_byte     = icon;
      return item;
   endfunction

   function automatic req_type random_request();
      req_type     item;
      int unsigned pick;
      logic [63:0] noise;
      noise = {$urandom, $urandom};
      item = noise[$bits(req_type)-1:0];
      item.op = ($urandom_range(99) < 75) ? OP_DECODE_BYTE : OP_PALETTE_WRITE;
      pick = $urandom_range(9);
      if (pick == 0)
         item.palette_color = 16'h0000;
      else if (pick == 1)
         item.palette_color = 16'h8000;
      return item;
   endfunction

   // Driver: the payload holds while stalled, and a new transaction is offered
   // from the head of the pending queue otherwise.
   always @(posedge clock) begin
      logic offer;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_request(req_data);
            void'(pending_requests.pop_front());
         end
         if (!(req_valid && req_stall)) begin
            offer = (pending_requests.size() != 0) &&
                    ($urandom_range(99) >= send_idle_pct);
            req_valid <= offer;
            if (offer)
               req_data <= pending_requests[0];
         end
      end
   end

   // Monitor: checks each accepted result and drives the receiver's stall.
   always @(posedge clock) begin
      rsp_type want;
      logic    stall_next;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               report_mismatch("unexpected result, address", 32'(rsp_data.pixel_address), 0);
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_data.pixel_address !== want.pixel_address)
                  report_mismatch("pixel_address", 32'(rsp_data.pixel_address),
                                  32'(want.pixel_address));
               if (rsp_data.left_rgba !== want.left_rgba)
                  report_mismatch("left_rgba", rsp_data.left_rgba, want.left_rgba);
               if (rsp_data.right_rgba !== want.right_rgba)
                  report_mismatch("right_rgba", rsp_data.right_rgba, want.right_rgba);
               if (rsp_data.icon_done !== want.icon_done)
                  report_mismatch("icon_done", 32'(rsp_data.icon_done), 32'(want.icon_done));
            end
         end
         if (long_hold_req && !long_hold_done) begin
            if (hold_count == LONG_HOLD) begin
               long_hold_done = 1'b1;
               stall_next     = 1'b0;
            end else begin
               hold_count++;
               stall_next = 1'b1;
            end
         end else begin
            stall_next = ($urandom_range(99) < recv_stall_pct);
         end
         rsp_stall <= stall_next;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
         $display("tb_tiled_4bpp_icon_to_rgba_top: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic wait_for_drain();
      while (pending_requests.size() != 0 || expected_pixels.size() != 0)
         @(negedge clock);
   endtask

   task automatic run_random_phase(input int idle_pct, input int stall_pct, input int count);
      @(negedge clock);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (count) pending_requests.push_back(random_request());
      wait_for_drain();
   endtask

   initial begin
      foreach (palette_model[i]) palette_model[i] = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Never-written entries read back as transparent black.
      pending_requests.push_back(make_request(OP_DECODE_BYTE, 4'hF, 16'hFFFF, 8'h00));
      pending_requests.push_back(make_request(OP_DECODE_BYTE, 4'h0, 16'h0000, 8'hFF));
      // Palette extremes; the icon byte is ignored on a palette write.
      pending_requests.push_back(make_request(OP_PALETTE_WRITE, 4'h0, 16'h0000, 8'hFF));
      pending_requests.push_back(make_request(OP_PALETTE_WRITE, 4'hF, 16'hFFFF, 8'hA5));
      pending_requests.push_back(make_request(OP_PALETTE_WRITE, 4'h1, 16'h8000, 8'h00));
      pending_requests.push_back(make_request(OP_PALETTE_WRITE, 4'h2, 16'h7FFF, 8'h5A));
      pending_requests.push_back(make_request(OP_PALETTE_WRITE, 4'h3, 16'h001F, 8'h00));
      pending_requests.push_back(make_request(OP_PALETTE_WRITE, 4'h4, 16'h03E0, 8'h00));
      pending_requests.push_back(make_request(OP_PALETTE_WRITE, 4'h5, 16'h7C00, 8'h00));
      pending_requests.push_back(make_request(OP_PALETTE_WRITE, 4'hA, 16'h5555, 8'h00));
      // Decodes; the palette fields ride along and must be ignored.
      pending_requests.push_back(make_request(OP_DECODE_BYTE, 4'hF, 16'hFFFF, 8'h00));
      pending_requests.push_back(make_request(OP_DECODE_BYTE, 4'h0, 16'h0000, 8'hFF));
      pending_requests.push_back(make_request(OP_DECODE_BYTE, 4'h7, 16'h1234, 8'h21));
      pending_requests.push_back(make_request(OP_DECODE_BYTE, 4'h0, 16'h0000, 8'h43));
      pending_requests.push_back(make_request(OP_DECODE_BYTE, 4'h0, 16'h0000, 8'h15));
      pending_requests.push_back(make_request(OP_DECODE_BYTE, 4'h0, 16'h0000, 8'hF1));
      pending_requests.push_back(make_request(OP_DECODE_BYTE, 4'h0, 16'h0000, 8'h6A));
      pending_requests.push_back(make_request(OP_PALETTE_WRITE, 4'h1, 16'h0000, 8'h11));
      pending_requests.push_back(make_request(OP_DECODE_BYTE, 4'h0, 16'h0000, 8'h11));
      pending_requests.push_back(make_request(OP_DECODE_BYTE, 4'h0, 16'h0000, 8'hAF));
      wait_for_drain();

      run_random_phase(0, 0, PHASE_ITEMS);
      run_random_phase(76, 0, PHASE_ITEMS);
      run_random_phase(0, 76, PHASE_ITEMS);
      run_random_phase(16, 16, PHASE_ITEMS);

      // Receiver holds off while the sender keeps offering, so the block backs up.
      @(negedge clock);
      long_hold_req = 1'b1;
      run_random_phase(0, 0, 100);
      long_hold_req = 1'b0;

      repeat (20) @(negedge clock);
      if (expected_pixels.size() != 0)
         report_mismatch("results never delivered", expected_pixels.size(), 0);
      if (error_count == 0)
         $display("tb_tiled_4bpp_icon_to_rgba_top: clean");
      else
         $display("tb_tiled_4bpp_icon_to_rgba_top: errors");
      $finish;
   end

endmodule

@@ tiled_4bpp_icon_to_rgba_top.f @@
rtl/core/t4icon_pkg.sv
rtl/core/t4icon_front.sv
rtl/core/t4icon_queue.sv
rtl/core/t4icon_back.sv
rtl/core/tiled_4bpp_icon_to_rgba_top.sv
rtl/core/t4icon_checker.sv
verif/tb_tiled_4bpp_icon_to_rgba_top.sv
